// File: rtl/core/cdiv_pkg.sv
// ----------------------------------------------------------------------------
// Complex divider package
// Types shared by the front end, the division cells and the output stage.
// ----------------------------------------------------------------------------
package cdiv_pkg;

  // Per-word status that travels alongside the division data.
  typedef struct packed {
    logic zero;    // divisor magnitude is zero
    logic neg_re;  // real numerator is negative
    logic neg_im;  // imaginary numerator is negative
  } cdiv_flags_t;

endpackage

// File: rtl/core/cdiv_front.sv
// ----------------------------------------------------------------------------
// Complex divider front end
// Forms the cross products, the two numerators and the shared denominator,
// then presents scaled magnitudes ready for the division chain.
// ----------------------------------------------------------------------------
module cdiv_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  parameter int REM_WIDTH  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [DATA_WIDTH-1:0]  a,
  input  logic signed [DATA_WIDTH-1:0]  b,
  input  logic signed [DATA_WIDTH-1:0]  c,
  input  logic signed [DATA_WIDTH-1:0]  d,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [REM_WIDTH-1:0]          rem_re,
  output logic [REM_WIDTH-1:0]          rem_im,
  output logic [REM_WIDTH-1:0]          dvs,
  output cdiv_pkg::cdiv_flags_t         flags
);
  import cdiv_pkg::*;

  localparam int PW = 2 * DATA_WIDTH;

  // Stage one: six signed products.
  logic                 valid1_r;
  logic                 ready1;
  logic signed [PW-1:0] p_ac_r, p_bd_r, p_bc_r, p_ad_r, p_cc_r, p_dd_r;
  logic signed [PW-1:0] p_ac_nxt, p_bd_nxt, p_bc_nxt, p_ad_nxt, p_cc_nxt, p_dd_nxt;

  // Stage two: numerators and denominator.
  logic                 valid2_r;
  logic                 ready2;
  logic [PW:0]          re_r, im_r, re_nxt, im_nxt;
  logic [PW-1:0]        den_r, den_nxt;

  // Stage three: magnitudes, signs and scaling.
  logic                 valid3_r;
  logic                 ready3;
  logic [PW:0]          mag_re, mag_im;
  logic [REM_WIDTH-1:0] rem_re_r, rem_im_r, dvs_r;
  logic [REM_WIDTH-1:0] rem_re_nxt, rem_im_nxt, dvs_nxt;
  cdiv_flags_t          flags_r, flags_nxt;

  // A stage may load when it is empty or its word moves on.
  assign ready1   = !valid1_r || ready2;
  assign ready2   = !valid2_r || ready3;
  assign ready3   = !valid3_r || dn_ready;
  assign up_ready = ready1;

  // Products are exact at twice the input width.
  always_comb begin
    p_ac_nxt = a * c;
    p_bd_nxt = b * d;
    p_bc_nxt = b * c;
    p_ad_nxt = a * d;
    p_cc_nxt = c * c;
    p_dd_nxt = d * d;
  end

  // Sign-extended sums; the squares are never negative.
  always_comb begin
    re_nxt  = {p_ac_r[PW-1], p_ac_r} + {p_bd_r[PW-1], p_bd_r};
    im_nxt  = {p_bc_r[PW-1], p_bc_r} - {p_ad_r[PW-1], p_ad_r};
    den_nxt = $unsigned(p_cc_r) + $unsigned(p_dd_r);
  end

  // Take magnitudes, scale the numerators by the fraction bits and line the
  // divisor up with the overflow bit of the quotient.
  always_comb begin
    mag_re           = re_r[PW] ? (~re_r + 1'b1) : re_r;
    mag_im           = im_r[PW] ? (~im_r + 1'b1) : im_r;
    rem_re_nxt       = REM_WIDTH'(mag_re[PW-1:0]) << FRAC_BITS;
    rem_im_nxt       = REM_WIDTH'(mag_im[PW-1:0]) << FRAC_BITS;
    dvs_nxt          = REM_WIDTH'(den_r) << DATA_WIDTH;
    flags_nxt.zero   = (den_r == '0);
    flags_nxt.neg_re = re_r[PW];
    flags_nxt.neg_im = im_r[PW];
  end

  // Valid flags for the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_r <= up_valid;
      end
      if (ready2) begin
        valid2_r <= valid1_r;
      end
      if (ready3) begin
        valid3_r <= valid2_r;
      end
    end
  end

  // Data registers load only when a word actually moves in.
  always_ff @(posedge clk) begin
    if (ready1 && up_valid) begin
      p_ac_r <= p_ac_nxt;
      p_bd_r <= p_bd_nxt;
      p_bc_r <= p_bc_nxt;
      p_ad_r <= p_ad_nxt;
      p_cc_r <= p_cc_nxt;
      p_dd_r <= p_dd_nxt;
    end
    if (ready2 && valid1_r) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      den_r <= den_nxt;
    end
    if (ready3 && valid2_r) begin
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      dvs_r    <= dvs_nxt;
      flags_r  <= flags_nxt;
    end
  end

  assign dn_valid = valid3_r;
  assign rem_re   = rem_re_r;
  assign rem_im   = rem_im_r;
  assign dvs      = dvs_r;
  assign flags    = flags_r;

endmodule

// File: rtl/core/cdiv_cell.sv
// ----------------------------------------------------------------------------
// Complex divider cell
// One restoring division step for both quotient parts: compare, subtract,
// record the quotient bit and halve the aligned divisor for the next cell.
// ----------------------------------------------------------------------------
module cdiv_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int REM_WIDTH  = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [REM_WIDTH-1:0]   up_rem_re,
  input  logic [REM_WIDTH-1:0]   up_rem_im,
  input  logic [REM_WIDTH-1:0]   up_dvs,
  input  logic [DATA_WIDTH:0]    up_q_re,
  input  logic [DATA_WIDTH:0]    up_q_im,
  input  cdiv_pkg::cdiv_flags_t  up_flags,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [REM_WIDTH-1:0]   dn_rem_re,
  output logic [REM_WIDTH-1:0]   dn_rem_im,
  output logic [REM_WIDTH-1:0]   dn_dvs,
  output logic [DATA_WIDTH:0]    dn_q_re,
  output logic [DATA_WIDTH:0]    dn_q_im,
  output cdiv_pkg::cdiv_flags_t  dn_flags
);
  import cdiv_pkg::*;

  logic                 valid_r;
  logic                 ge_re, ge_im;
  logic [REM_WIDTH-1:0] rem_re_r, rem_im_r, dvs_r;
  logic [REM_WIDTH-1:0] rem_re_nxt, rem_im_nxt, dvs_nxt;
  logic [DATA_WIDTH:0]  q_re_r, q_im_r, q_re_nxt, q_im_nxt;
  cdiv_flags_t          flags_r;

  assign up_ready = !valid_r || dn_ready;

  // Both parts share the divisor, so one shift serves the two lanes.
  always_comb begin
    ge_re      = (up_rem_re >= up_dvs);
    ge_im      = (up_rem_im >= up_dvs);
    rem_re_nxt = ge_re ? (up_rem_re - up_dvs) : up_rem_re;
    rem_im_nxt = ge_im ? (up_rem_im - up_dvs) : up_rem_im;
    q_re_nxt   = {up_q_re[DATA_WIDTH-1:0], ge_re};
    q_im_nxt   = {up_q_im[DATA_WIDTH-1:0], ge_im};
    dvs_nxt    = up_dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      dvs_r    <= dvs_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      flags_r  <= up_flags;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_rem_re = rem_re_r;
  assign dn_rem_im = rem_im_r;
  assign dn_dvs    = dvs_r;
  assign dn_q_re   = q_re_r;
  assign dn_q_im   = q_im_r;
  assign dn_flags  = flags_r;

endmodule

// File: rtl/core/cdiv_back.sv
// ----------------------------------------------------------------------------
// Complex divider output stage
// Clamps each quotient magnitude to the signed range, restores the sign,
// applies the zero-divisor rule and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module cdiv_back #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [DATA_WIDTH:0]           up_q_re,
  input  logic [DATA_WIDTH:0]           up_q_im,
  input  cdiv_pkg::cdiv_flags_t         up_flags,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [DATA_WIDTH-1:0]  quotient_real,
  output logic signed [DATA_WIDTH-1:0]  quotient_imag,
  output logic                          divisor_zero,
  output logic                          saturated
);
  import cdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] lim_re, lim_im;
  logic [DATA_WIDTH-1:0] qc_re, qc_im;
  logic                  sat_re, sat_im;
  logic [DATA_WIDTH-1:0] q_re_r, q_im_r, q_re_nxt, q_im_nxt;
  logic                  zero_r, sat_r, zero_nxt, sat_nxt;

  assign up_ready = !valid_r || dn_ready;

  // The limit is 2^(W-1) for a negative part and 2^(W-1)-1 otherwise. The
  // top quotient bit means the magnitude reached 2^W and always clamps.
  always_comb begin
    lim_re = {up_flags.neg_re, {(DATA_WIDTH-1){!up_flags.neg_re}}};
    lim_im = {up_flags.neg_im, {(DATA_WIDTH-1){!up_flags.neg_im}}};
    sat_re = up_q_re[DATA_WIDTH] || (up_q_re[DATA_WIDTH-1:0] > lim_re);
    sat_im = up_q_im[DATA_WIDTH] || (up_q_im[DATA_WIDTH-1:0] > lim_im);
    qc_re  = sat_re ? lim_re : up_q_re[DATA_WIDTH-1:0];
    qc_im  = sat_im ? lim_im : up_q_im[DATA_WIDTH-1:0];
    if (up_flags.zero) begin
      q_re_nxt = '0;
      q_im_nxt = '0;
      sat_nxt  = 1'b0;
    end else begin
      q_re_nxt = up_flags.neg_re ? (~qc_re + ONE) : qc_re;
      q_im_nxt = up_flags.neg_im ? (~qc_im + ONE) : qc_im;
      sat_nxt  = sat_re || sat_im;
    end
    zero_nxt = up_flags.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q_re_r <= q_re_nxt;
      q_im_r <= q_im_nxt;
      zero_r <= zero_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign dn_valid      = valid_r;
  assign quotient_real = q_re_r;
  assign quotient_imag = q_im_r;
  assign divisor_zero  = zero_r;
  assign saturated     = sat_r;

endmodule

// File: rtl/core/complex_divider_top.sv
// ----------------------------------------------------------------------------
// Complex divider
// Pipelined fixed-point complex quotient (a+bi)/(c+di) with truncation,
// saturation and a zero-divisor flag.
// ----------------------------------------------------------------------------
//
//   Channel  | Ports                                    | Direction
//   ---------+------------------------------------------+-----------
//   input    | in_valid, in_stall, in_dividend_*,       | into block
//            | in_divisor_*                             |
//   result   | out_valid, out_stall, out_quotient_*,    | out of block
//            | out_divisor_zero, out_saturated          |
//
// One word is taken every clock while the input is not stalled; a word passes
// through three front-end stages, one division cell per quotient bit plus an
// overflow cell, and the output register.
// Every stage has its own valid bit, so empty stages keep filling while the
// result word is stalled; the input stalls only once the whole chain is full.
// Reset is synchronous and clears the valid bits only.
// ----------------------------------------------------------------------------
module complex_divider_top #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_dividend_real,
  input  logic signed [DATA_WIDTH-1:0]  in_dividend_imag,
  input  logic signed [DATA_WIDTH-1:0]  in_divisor_real,
  input  logic signed [DATA_WIDTH-1:0]  in_divisor_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_quotient_real,
  output logic signed [DATA_WIDTH-1:0]  out_quotient_imag,
  output logic                          out_divisor_zero,
  output logic                          out_saturated
);
  import cdiv_pkg::*;

  // Remainders must hold the scaled numerator and the divisor aligned with
  // the overflow bit.
  localparam int REM_WIDTH = (FRAC_BITS > DATA_WIDTH) ? (2 * DATA_WIDTH + FRAC_BITS)
                                                      : (3 * DATA_WIDTH);
  localparam int NCELL     = DATA_WIDTH + 1;

  logic                 front_ready;
  logic [NCELL:0]       c_valid, c_ready;
  logic [REM_WIDTH-1:0] c_rem_re [NCELL];
  logic [REM_WIDTH-1:0] c_rem_im [NCELL];
  logic [REM_WIDTH-1:0] c_dvs    [NCELL];
  logic [DATA_WIDTH:0]  c_q_re   [NCELL+1];
  logic [DATA_WIDTH:0]  c_q_im   [NCELL+1];
  cdiv_flags_t          c_flags  [NCELL+1];

  assign in_stall = !front_ready;

  // Products, numerators, denominator and scaling.
  cdiv_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .REM_WIDTH  (REM_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .a        (in_dividend_real),
    .b        (in_dividend_imag),
    .c        (in_divisor_real),
    .d        (in_divisor_imag),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .rem_re   (c_rem_re[0]),
    .rem_im   (c_rem_im[0]),
    .dvs      (c_dvs[0]),
    .flags    (c_flags[0])
  );

  // The quotient is built up from nothing, most significant bit first.
  assign c_q_re[0] = '0;
  assign c_q_im[0] = '0;

  // Row of division cells; the last one has no remainder to pass on.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i < NCELL - 1) begin : g_mid
      cdiv_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .REM_WIDTH  (REM_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (c_valid[i]),
        .up_ready  (c_ready[i]),
        .up_rem_re (c_rem_re[i]),
        .up_rem_im (c_rem_im[i]),
        .up_dvs    (c_dvs[i]),
        .up_q_re   (c_q_re[i]),
        .up_q_im   (c_q_im[i]),
        .up_flags  (c_flags[i]),
        .dn_valid  (c_valid[i+1]),
        .dn_ready  (c_ready[i+1]),
        .dn_rem_re (c_rem_re[i+1]),
        .dn_rem_im (c_rem_im[i+1]),
        .dn_dvs    (c_dvs[i+1]),
        .dn_q_re   (c_q_re[i+1]),
        .dn_q_im   (c_q_im[i+1]),
        .dn_flags  (c_flags[i+1])
      );
    end else begin : g_last
      cdiv_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .REM_WIDTH  (REM_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (c_valid[i]),
        .up_ready  (c_ready[i]),
        .up_rem_re (c_rem_re[i]),
        .up_rem_im (c_rem_im[i]),
        .up_dvs    (c_dvs[i]),
        .up_q_re   (c_q_re[i]),
        .up_q_im   (c_q_im[i]),
        .up_flags  (c_flags[i]),
        .dn_valid  (c_valid[i+1]),
        .dn_ready  (c_ready[i+1]),
        .dn_rem_re (),
        .dn_rem_im (),
        .dn_dvs    (),
        .dn_q_re   (c_q_re[i+1]),
        .dn_q_im   (c_q_im[i+1]),
        .dn_flags  (c_flags[i+1])
      );
    end
  end

  // Clamp, sign and hold the result word.
  cdiv_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (c_valid[NCELL]),
    .up_ready      (c_ready[NCELL]),
    .up_q_re       (c_q_re[NCELL]),
    .up_q_im       (c_q_im[NCELL]),
    .up_flags      (c_flags[NCELL]),
    .dn_valid      (out_valid),
    .dn_ready      (!out_stall),
    .quotient_real (out_quotient_real),
    .quotient_imag (out_quotient_imag),
    .divisor_zero  (out_divisor_zero),
    .saturated     (out_saturated)
  );

endmodule

// File: rtl/core/cdiv_checker.sv
// ----------------------------------------------------------------------------
// Complex divider checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cdiv_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [DATA_WIDTH-1:0]  out_quotient_real,
  input logic signed [DATA_WIDTH-1:0]  out_quotient_imag,
  input logic                          out_divisor_zero,
  input logic                          out_saturated
);

  localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // A stalled result word stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quotient_real) &&
      $stable(out_quotient_imag) && $stable(out_divisor_zero) &&
      $stable(out_saturated))
    else $error("result word changed while stalled");

  // A zero divisor gives a zero quotient and no saturation.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divisor_zero |->
      out_quotient_real == '0 && out_quotient_imag == '0 && !out_saturated)
    else $error("zero divisor with non-zero quotient or saturation");

  // Saturation always leaves at least one part at an end of the range.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      $unsigned(out_quotient_real) == Q_MAX || $unsigned(out_quotient_real) == Q_MIN ||
      $unsigned(out_quotient_imag) == Q_MAX || $unsigned(out_quotient_imag) == Q_MIN)
    else $error("saturation flagged but neither part is at a limit");

  // Reset empties the pipeline, so nothing is presented straight after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

endmodule

bind complex_divider_top cdiv_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_cdiv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_quotient_real (out_quotient_real),
  .out_quotient_imag (out_quotient_imag),
  .out_divisor_zero  (out_divisor_zero),
  .out_saturated     (out_saturated)
);
